// ===== hdl/vtdi_pkg.sv =====
`default_nettype none

package vtdi_pkg;

  // Number of points in the calibration ROM and default parameter values.
  localparam int unsigned ROM_POINTS     = 21;
  localparam int unsigned CAL_POINTS_DEF = 21;
  localparam int unsigned DUTY_BITS_DEF  = 10;

  // Width of the ROM fields, of the voltage request and of the divider.
  localparam int unsigned VAL_W = 16;

  // Width of the duty result port.
  localparam int unsigned DUTY_OUT_W = 10;

  // Result status codes.
  localparam logic STAT_OK    = 1'b0;
  localparam logic STAT_RANGE = 1'b1;

  // Calibration ROM, ordered by rising duty and falling voltage.
  localparam logic [VAL_W-1:0] CAL_DUTY [ROM_POINTS] = '{
    16'd358, 16'd389, 16'd420, 16'd451, 16'd482,
    16'd514, 16'd545, 16'd576, 16'd607, 16'd638,
    16'd670, 16'd701, 16'd732, 16'd763, 16'd794,
    16'd826, 16'd857, 16'd888, 16'd919, 16'd950,
    16'd982
  };

  localparam logic [VAL_W-1:0] CAL_MV [ROM_POINTS] = '{
    16'd4206, 16'd4197, 16'd4183, 16'd4166, 16'd4131,
    16'd4080, 16'd4006, 16'd3902, 16'd3757, 16'd3569,
    16'd3312, 16'd3012, 16'd2654, 16'd2269, 16'd1892,
    16'd1569, 16'd1396, 16'd1357, 16'd1343, 16'd1329,
    16'd1326
  };

endpackage

`default_nettype wire

// ===== hdl/vtdi_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in VAL_W bits (upper dividend half below the divisor).
module vtdi_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [2*vtdi_pkg::VAL_W-1:0]  dividend_i,
  input  wire logic [vtdi_pkg::VAL_W-1:0]    divisor_i,
  output logic      [vtdi_pkg::VAL_W-1:0]    quotient_o,
  output logic                               done_o
);
  import vtdi_pkg::*;

  localparam int unsigned CntW = $clog2(VAL_W + 1);

  logic [VAL_W-1:0] rem_q, rem_d;
  logic [VAL_W-1:0] num_q, num_d;
  logic [VAL_W-1:0] div_q, div_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [VAL_W:0]   trial;
  logic             fits;

  always_comb begin
    trial  = {rem_q, num_q[VAL_W-1]};
    fits   = (trial >= {1'b0, div_q});
    rem_d  = rem_q;
    num_d  = num_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = dividend_i[2*VAL_W-1:VAL_W];
      num_d = dividend_i[VAL_W-1:0];
      div_d = divisor_i;
      cnt_d = CntW'(VAL_W);
    end else if (cnt_q != '0) begin
      if (fits) begin
        rem_d = VAL_W'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[VAL_W-1:0];
      end
      num_d = {num_q[VAL_W-2:0], fits};
      cnt_d = cnt_q - CntW'(1);
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    div_q <= div_d;
  end

  assign quotient_o = num_q;
  assign done_o     = done_q;

endmodule

`default_nettype wire

// ===== hdl/voltage_to_duty_interp_core.sv =====
// Maps a requested regulator voltage in millivolts to a PWM duty by linear
// interpolation over a fixed calibration ROM of (duty, voltage) points.
// Input channel: in_valid_i / in_stall_o with voltage_request_i. Output
// channel: out_valid_o / out_stall_i with duty_out_o and status_o. Each
// transfer on the input gives exactly one transfer on the output.
// A request outside the calibrated voltage range returns status 1 and the
// previously applied duty, which is left unchanged, and goes straight to
// the S_OUT state. An in-range request scans the ROM one segment per cycle,
// forms the offset product on one multiplier and divides it by the segment
// span in a bit-serial divider (a zero span takes the duty of the segment's
// first point) before it reaches S_OUT, which loads the output register.
// One request is in flight at a time; in_stall_o is high while it is worked
// on, and the next request can be taken while the result is presented.
// A finished result waits in the output register while out_stall_i is high,
// and the block then holds before loading the next result. Reset clears
// the applied duty and empties the output register.
`default_nettype none

module voltage_to_duty_interp_core #(
  parameter int unsigned CAL_POINTS = vtdi_pkg::CAL_POINTS_DEF,
  parameter int unsigned DUTY_BITS  = vtdi_pkg::DUTY_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] voltage_request_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [9:0]  duty_out_o,
  output logic             status_o
);
  import vtdi_pkg::*;

  // Points actually used; the ROM limits the count.
  localparam int unsigned NumPts = (CAL_POINTS > ROM_POINTS) ? ROM_POINTS : CAL_POINTS;
  localparam int unsigned IdxW   = $clog2(NumPts);
  localparam logic [IdxW-1:0] LastSeg = IdxW'(NumPts - 2);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;
  localparam logic [2:0] S_START = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [VAL_W-1:0]     mv_q, mv_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic [VAL_W-1:0]     d0_q, d0_d;
  logic [VAL_W-1:0]     dd_q, dd_d;
  logic [VAL_W-1:0]     off_q, off_d;
  logic [VAL_W-1:0]     span_q, span_d;
  logic [2*VAL_W-1:0]   prod_q, prod_d;
  logic [DUTY_BITS-1:0] applied_q, applied_d;
  logic                 stat_q, stat_d;
  logic                 out_valid_q, out_valid_d;
  logic [9:0]           duty_out_q, duty_out_d;
  logic                 status_q, status_d;

  logic                 div_start;
  logic [VAL_W-1:0]     div_quot;
  logic                 div_done;

  logic [IdxW-1:0]      idx_nxt;
  logic [VAL_W-1:0]     hi_v, lo_v, hi_d, lo_d;
  logic                 hit;
  logic                 out_range;
  logic [VAL_W:0]       sum;
  logic [15:0]          applied_ext;

  vtdi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (span_q),
    .quotient_o (div_quot),
    .done_o     (div_done)
  );

  always_comb begin
    idx_nxt   = idx_q + IdxW'(1);
    hi_v      = CAL_MV[idx_q];
    lo_v      = CAL_MV[idx_nxt];
    hi_d      = CAL_DUTY[idx_q];
    lo_d      = CAL_DUTY[idx_nxt];
    hit       = (mv_q <= hi_v) && (mv_q >= lo_v);
    out_range = (voltage_request_i < CAL_MV[NumPts-1]) || (voltage_request_i > CAL_MV[0]);
    sum       = {1'b0, d0_q} + {1'b0, div_quot};
    applied_ext = 16'(applied_q);

    state_d     = state_q;
    mv_d        = mv_q;
    idx_d       = idx_q;
    d0_d        = d0_q;
    dd_d        = dd_q;
    off_d       = off_q;
    span_d      = span_q;
    prod_d      = prod_q;
    applied_d   = applied_q;
    stat_d      = stat_q;
    div_start   = 1'b0;
    out_valid_d = out_valid_q;
    duty_out_d  = duty_out_q;
    status_d    = status_q;

    // The output register empties when the receiver takes the result.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mv_d  = voltage_request_i;
          idx_d = '0;
          if (out_range) begin
            stat_d  = STAT_RANGE;
            state_d = S_OUT;
          end else begin
            stat_d  = STAT_OK;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          d0_d    = hi_d;
          dd_d    = (lo_d >= hi_d) ? (lo_d - hi_d) : '0;
          off_d   = hi_v - mv_q;
          span_d  = hi_v - lo_v;
          state_d = S_MUL;
        end else if (idx_q == LastSeg) begin
          // No segment brackets the request: take the last point's duty.
          applied_d = DUTY_BITS'(CAL_DUTY[NumPts-1]);
          state_d   = S_OUT;
        end else begin
          idx_d = idx_nxt;
        end
      end
      S_MUL: begin
        prod_d = dd_q * off_q;
        if (span_q == '0) begin
          applied_d = DUTY_BITS'(d0_q);
          state_d   = S_OUT;
        end else begin
          state_d = S_START;
        end
      end
      S_START: begin
        // The divider starts in the cycle after the product is registered.
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          applied_d = DUTY_BITS'(sum);
          state_d   = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          duty_out_d  = applied_ext[9:0];
          status_d    = stat_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      applied_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      applied_q   <= applied_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mv_q       <= mv_d;
    idx_q      <= idx_d;
    d0_q       <= d0_d;
    dd_q       <= dd_d;
    off_q      <= off_d;
    span_q     <= span_d;
    prod_q     <= prod_d;
    stat_q     <= stat_d;
    duty_out_q <= duty_out_d;
    status_q   <= status_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign duty_out_o  = duty_out_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import vtdi_pkg::*;

  // The calibration table has its first point at the highest voltage and its
  // last point at the lowest voltage. The two end voltages bound the
  // accepted request range.
  localparam int unsigned LAST_POINT = ROM_POINTS - 1;
  localparam int unsigned MV_TOP     = CAL_MV[0];
  localparam int unsigned MV_BOTTOM  = CAL_MV[LAST_POINT];

  // This many cycles let the slowest request (the deepest segment plus the
  // serial divide) finish after the last expected transfer.
  localparam int unsigned DRAIN_CYCLES = 64;

  // Length of the long receiver hold-off that makes the block back up.
  localparam int unsigned LONG_HOLD = 300;

  // Only the first few mismatches are printed in full.
  localparam int unsigned MAX_REPORTS = 10;

  // One predicted result: the applied duty and the status of the request.
  typedef struct packed {
    logic [DUTY_OUT_W-1:0] duty;
    logic                  status;
  } duty_status_t;

  // Clock and reset. Every block input holds a known value from time zero.
  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        in_valid_i        = 1'b0;
  logic [15:0] voltage_request_i = '0;
  logic        out_stall_i       = 1'b0;

  logic                  in_stall_o;
  logic                  out_valid_o;
  logic [DUTY_OUT_W-1:0] duty_out_o;
  logic                  status_o;

  // The predictor keeps its own copy of the duty that is currently applied.
  logic [DUTY_OUT_W-1:0] predicted_applied_duty;

  // Results that were predicted at input transfers and not yet seen at the
  // output, oldest first.
  duty_status_t pending_results_q[$];

  int unsigned mismatch_count = 0;

  // When set, both sides stop idling so that requests run back to back.
  bit full_rate = 1'b0;

  // When set, the receiver takes the long LONG_HOLD hold-off after the next
  // output transfer. The receiver process clears it once the hold starts.
  bit long_hold_req = 1'b0;

  voltage_to_duty_interp_core i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .voltage_request_i (voltage_request_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .duty_out_o        (duty_out_o),
    .status_o          (status_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Piecewise linear lookup. A request outside the calibrated range keeps
  // the applied duty and flags a range error. Otherwise the first segment
  // whose end voltages bracket the request, both ends included, is used, so
  // a request on a shared point takes the lower-duty segment. The offset
  // product is divided by the segment span with truncation. A flat segment
  // would return its lower duty instead of dividing by zero.
  function automatic duty_status_t calc_duty(input logic [15:0] mv);
    duty_status_t res;
    int unsigned  hi_v;
    int unsigned  lo_v;
    int unsigned  span;
    int unsigned  off;
    int unsigned  dd;
    int unsigned  duty;
    bit           found;
    found = 1'b0;
    duty  = CAL_DUTY[LAST_POINT];
    if (mv < MV_BOTTOM || mv > MV_TOP) begin
      res.status = STAT_RANGE;
    end else begin
      if (mv >= MV_TOP) begin
        duty = CAL_DUTY[0];
      end else if (mv <= MV_BOTTOM) begin
        duty = CAL_DUTY[LAST_POINT];
      end else begin
        for (int i = 0; i < LAST_POINT; i++) begin
          hi_v = CAL_MV[i];
          lo_v = CAL_MV[i+1];
          if (!found && mv <= hi_v && mv >= lo_v) begin
            found = 1'b1;
            span  = hi_v - lo_v;
            off   = hi_v - mv;
            dd    = (CAL_DUTY[i+1] >= CAL_DUTY[i]) ? CAL_DUTY[i+1] - CAL_DUTY[i] : 0;
            if (span == 0) begin
              duty = CAL_DUTY[i];
            end else begin
              duty = CAL_DUTY[i] + (dd * off) / span;
            end
          end
        end
      end
      // The computed duty is cut down to the duty width of the block.
      predicted_applied_duty = duty[DUTY_BITS_DEF-1:0];
      res.status = STAT_OK;
    end
    res.duty = predicted_applied_duty;
    return res;
  endfunction

  // Offers one request after a random gap and holds it until the block
  // takes it. The valid stays high on return so that a following request
  // with no gap is offered without a dead cycle; park_sender lowers it.
  task automatic drive_request(input logic [15:0] mv);
    int unsigned gap;
    gap = full_rate ? 0 : $urandom_range(4, 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    voltage_request_i <= mv;
    // Stall is sampled as it stood just before the edge, so a low stall
    // here means this edge completed the transfer.
    do @(posedge clk_i); while (in_stall_o);
    pending_results_q.push_back(calc_duty(mv));
  endtask

  task automatic park_sender();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_results_done();
    while (pending_results_q.size() != 0) @(posedge clk_i);
  endtask

  // Random request: mostly inside the calibrated range, some right around
  // the table points where segments meet, and some over the whole 16-bit
  // range so that every request bit toggles and range errors keep coming.
  function automatic logic [15:0] random_request();
    int unsigned pick;
    int unsigned idx;
    int          mv;
    pick = $urandom_range(99, 0);
    if (pick < 65) begin
      mv = $urandom_range(MV_TOP, MV_BOTTOM);
    end else if (pick < 80) begin
      idx = $urandom_range(LAST_POINT, 0);
      mv  = int'(CAL_MV[idx]) + int'($urandom_range(4, 0)) - 2;
    end else begin
      mv = $urandom() & 32'hFFFF;
    end
    return mv[15:0];
  endfunction

  // Receiver. For every result it holds off for a random number of cycles,
  // or not at all at full rate, then drops the stall and waits for the next
  // transfer. A requested long hold-off replaces one of the short ones.
  initial begin
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req) begin
        hold          = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        hold = full_rate ? 0 : $urandom_range(4, 0);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Result checker. Each output transfer is compared with the oldest
  // prediction. Values are read as they stood just before the edge.
  always @(posedge clk_i) begin
    duty_status_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("%0t: unexpected result duty=%0d status=%0d",
                   $realtime, duty_out_o, status_o);
        end
      end else begin
        exp_res = pending_results_q.pop_front();
        if (duty_out_o !== exp_res.duty || status_o !== exp_res.status) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: mismatch duty exp=%0d got=%0d, status exp=%0d got=%0d",
                     $realtime, exp_res.duty, duty_out_o, exp_res.status, status_o);
          end
        end
      end
    end
  end

  // A range error before any in-range request must return the reset duty.
  task automatic test_reset_duty();
    drive_request(16'(MV_TOP + 1));
    drive_request(16'd0);
    park_sender();
    wait_results_done();
  endtask

  // Range edges, both table ends, shared segment points, flat-looking
  // bottom segments and the full-scale request values.
  task automatic test_directed_edges();
    logic [15:0] edge_mv[$];
    edge_mv = '{16'(MV_TOP), 16'(MV_BOTTOM), 16'hFFFF, 16'(MV_BOTTOM - 1),
                16'(MV_TOP - 1), 16'(MV_BOTTOM + 1), 16'(MV_TOP + 1),
                16'd4197, 16'd3312, 16'd3313, 16'd3311, 16'd2269, 16'd1329,
                16'd1343, 16'd1396, 16'd2000, 16'h8000, 16'h7FFF, 16'd1328};
    foreach (edge_mv[i]) drive_request(edge_mv[i]);
    park_sender();
    wait_results_done();
  endtask

  // Back-to-back requests with neither side idling.
  task automatic test_full_rate();
    full_rate = 1'b1;
    repeat (150) drive_request(random_request());
    park_sender();
    wait_results_done();
    full_rate = 1'b0;
  endtask

  // The receiver holds off for a long stretch while requests keep coming,
  // so the output register fills and the block stalls its input.
  task automatic test_backpressure();
    long_hold_req = 1'b1;
    repeat (20) drive_request(random_request());
    park_sender();
    wait_results_done();
  endtask

  task automatic test_random();
    repeat (1200) drive_request(random_request());
    park_sender();
    wait_results_done();
  endtask

  initial begin
    predicted_applied_duty = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_duty();
    test_directed_edges();
    test_full_rate();
    test_backpressure();
    test_random();

    // Give the block time to show any result that was never predicted.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog. A correct run needs well under a tenth of this time.
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/vtdi_pkg.sv
hdl/vtdi_div.sv
hdl/voltage_to_duty_interp_core.sv
verif/tb_top.sv
